[rtl/klerp_pkg.sv]
// Shared types, codes and constants of the keyframe interpolation engine.
package klerp_pkg;

  localparam logic [1:0] MODE_WR_TIME  = 2'd0;
  localparam logic [1:0] MODE_WR_VALUE = 2'd1;
  localparam logic [1:0] MODE_QUERY    = 2'd2;

  localparam int unsigned MAX_OUT   = 8;
  localparam int unsigned DIV_STEPS = 16;

  localparam logic [15:0] HALF_DAY = 16'h8000;
  localparam logic [34:0] ROUND_HALF = 35'h0_0000_8000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  key_index;
    logic [2:0]  channel_index;
    logic [15:0] write_value;
    logic [15:0] day_ratio;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] value;
    logic [15:0] weight;
    logic [2:0]  lower_key;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RD_LO,
    S_RD_HI,
    S_PREP,
    S_DIV,
    S_OUT,
    S_DRAIN
  } state_e;

endpackage

[rtl/keyframe_lerp_engine_core.sv]
// Keyframe table with segment search, serial weight divider and per-channel interpolation.
//
// After reset the block clears its key time and channel value memories in a pass over all
// NUM_KEYS*NUM_CHANNELS value entries with busy high. A write word (mode 0 or 1) is taken
// in idle and leaves busy low. A query word scans the key times one per cycle, fetches
// the two segment times (states S_RD_LO, S_RD_HI and S_PREP), runs a restoring divider for
// the weight (skipped when the span is zero or the weight saturates), then reads both
// keys' channel values through two memory read ports and emits one result word per cycle,
// min(NUM_CHANNELS,8) words in all, through the value read registers and the result
// register. Results of one query arrive on consecutive cycles, each marked by res_valid_o
// for exactly one cycle; the receiver cannot stall them.
module keyframe_lerp_engine_core #(
  parameter int NUM_KEYS     = 8,
  parameter int NUM_CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  klerp_pkg::in_word_t  item_i,
  output logic                 res_valid_o,
  output klerp_pkg::out_word_t res_o
);

  localparam int KW    = $clog2(NUM_KEYS);
  localparam int DEPTH = NUM_KEYS * NUM_CHANNELS;
  localparam int VW    = $clog2(DEPTH);
  localparam int NOUT  = (NUM_CHANNELS < klerp_pkg::MAX_OUT) ? NUM_CHANNELS
                                                             : klerp_pkg::MAX_OUT;

  localparam logic [KW-1:0] LAST_KEY   = KW'(NUM_KEYS - 1);
  localparam logic [VW-1:0] LAST_ENTRY = VW'(DEPTH - 1);
  localparam logic [2:0]    LAST_CH    = 3'(NOUT - 1);
  localparam logic [3:0]    LAST_STEP  = 4'(klerp_pkg::DIV_STEPS - 1);

  logic [15:0] kt_mem [NUM_KEYS];
  logic [15:0] kv_mem [DEPTH];

  klerp_pkg::state_e state_q, state_d;

  logic [VW-1:0] clr_q;
  logic [KW-1:0] scan_q;
  logic          cmp_vld_q;
  logic [KW-1:0] cmp_idx_q;
  logic [KW-1:0] lo_q, hi_q;
  logic [15:0]   time_q;
  logic [15:0]   t0_q;
  logic [15:0]   kt_rdata_q;
  logic [15:0]   rem_q, span_q, w_q;
  logic [3:0]    step_q;
  logic [VW-1:0] lo_base_q, hi_base_q;
  logic [2:0]    ch_q;
  logic          rd_vld_q;
  logic [2:0]    rd_ch_q;
  logic          rd_last_q;
  logic [15:0]   v0_q, v1_q;
  logic          res_valid_q;
  klerp_pkg::out_word_t res_q;

  logic          accept;
  logic          clearing;
  logic          issue;
  logic [KW-1:0] kt_raddr;
  logic          hit, scan_done;
  logic [KW-1:0] hi_sel, lo_sel;
  logic [16:0]   t1x, timex;
  logic [15:0]   d_val, span_val;
  logic          skip_div;
  logic [16:0]   rem2;
  logic          ge;
  logic [VW-1:0] kv_raddr0, kv_raddr1;
  logic [6:0]    kidx_w, cidx_w, lo_w;
  logic          key_ok, chan_ok;
  logic [12:0]   kv_wlin, lo_lin, hi_lin;
  logic          kt_we, kv_we;
  logic [KW-1:0] kt_waddr;
  logic [VW-1:0] kv_waddr;
  logic [15:0]   wdata;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [34:0] acc;

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      klerp_pkg::S_CLEAR: begin
        if (clr_q == LAST_ENTRY) state_d = klerp_pkg::S_IDLE;
      end
      klerp_pkg::S_IDLE: begin
        if (start && item_i.mode == klerp_pkg::MODE_QUERY) state_d = klerp_pkg::S_SCAN;
      end
      klerp_pkg::S_SCAN: begin
        if (scan_done) state_d = klerp_pkg::S_RD_LO;
      end
      klerp_pkg::S_RD_LO: state_d = klerp_pkg::S_RD_HI;
      klerp_pkg::S_RD_HI: state_d = klerp_pkg::S_PREP;
      klerp_pkg::S_PREP: begin
        state_d = skip_div ? klerp_pkg::S_OUT : klerp_pkg::S_DIV;
      end
      klerp_pkg::S_DIV: begin
        if (step_q == LAST_STEP) state_d = klerp_pkg::S_OUT;
      end
      klerp_pkg::S_OUT: begin
        if (ch_q == LAST_CH) state_d = klerp_pkg::S_DRAIN;
      end
      klerp_pkg::S_DRAIN: begin
        if (!rd_vld_q) state_d = klerp_pkg::S_IDLE;
      end
      default: state_d = klerp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    clearing = 1'b0;
    issue    = 1'b0;
    kt_raddr = scan_q;
    unique case (state_q)
      klerp_pkg::S_CLEAR: clearing = 1'b1;
      klerp_pkg::S_IDLE:  busy = 1'b0;
      klerp_pkg::S_RD_LO: kt_raddr = lo_q;
      klerp_pkg::S_RD_HI: kt_raddr = hi_q;
      klerp_pkg::S_OUT:   issue = 1'b1;
      default: ;
    endcase
  end

  // Segment search, span arithmetic, divider compare and value read addresses.
  always_comb begin
    hit       = time_q < kt_rdata_q;
    scan_done = cmp_vld_q && (hit || cmp_idx_q == LAST_KEY);
    hi_sel    = hit ? cmp_idx_q : '0;
    lo_sel    = (hi_sel == '0) ? LAST_KEY : hi_sel - KW'(1);
    t1x       = (kt_rdata_q < t0_q) ? {1'b1, kt_rdata_q} : {1'b0, kt_rdata_q};
    timex     = (time_q < t0_q) ? {1'b1, time_q} : {1'b0, time_q};
    d_val     = 16'(timex - {1'b0, t0_q});
    span_val  = 16'(t1x - {1'b0, t0_q});
    skip_div  = (span_val == 16'h0000) || (d_val >= span_val);
    rem2      = {rem_q, 1'b0};
    ge        = rem2 >= {1'b0, span_q};
    lo_lin    = 13'(lo_q) * 13'(NUM_CHANNELS);
    hi_lin    = 13'(hi_q) * 13'(NUM_CHANNELS);
    kv_raddr0 = lo_base_q + VW'(ch_q);
    kv_raddr1 = hi_base_q + VW'(ch_q);
  end

  // Memory write port: clearing pass or a write word.
  always_comb begin
    kidx_w   = 7'(item_i.key_index);
    cidx_w   = 7'(item_i.channel_index);
    key_ok   = kidx_w < 7'(NUM_KEYS);
    chan_ok  = cidx_w < 7'(NUM_CHANNELS);
    kv_wlin  = 13'(item_i.key_index) * 13'(NUM_CHANNELS) + 13'(item_i.channel_index);
    kt_we    = 1'b0;
    kv_we    = 1'b0;
    kt_waddr = kidx_w[KW-1:0];
    kv_waddr = kv_wlin[VW-1:0];
    wdata    = item_i.write_value;
    if (clearing) begin
      kv_we    = 1'b1;
      kt_we    = 13'(clr_q) < 13'(NUM_KEYS);
      kt_waddr = clr_q[KW-1:0];
      kv_waddr = clr_q;
      wdata    = '0;
    end else if (accept) begin
      kt_we = (item_i.mode == klerp_pkg::MODE_WR_TIME) && key_ok;
      kv_we = (item_i.mode == klerp_pkg::MODE_WR_VALUE) && key_ok && chan_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (kt_we) kt_mem[kt_waddr] <= wdata;
    kt_rdata_q <= kt_mem[kt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) kv_mem[kv_waddr] <= wdata;
    v0_q <= kv_mem[kv_raddr0];
    v1_q <= kv_mem[kv_raddr1];
  end

  // Interpolation: v0 + (v1 - v0) * w, rounded to nearest.
  always_comb begin
    diff  = $signed({1'b0, v1_q}) - $signed({1'b0, v0_q});
    prod  = diff * $signed({1'b0, w_q});
    acc   = $signed({3'b000, v0_q, 16'h0000}) + 35'(prod) + $signed(klerp_pkg::ROUND_HALF);
    lo_w  = 7'(lo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= klerp_pkg::S_CLEAR;
      clr_q       <= '0;
      cmp_vld_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (clearing) clr_q <= clr_q + VW'(1);
      cmp_vld_q   <= (state_q == klerp_pkg::S_SCAN) && !scan_done;
      rd_vld_q    <= issue;
      res_valid_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_q;
    rd_ch_q   <= ch_q;
    rd_last_q <= ch_q == LAST_CH;
    unique case (state_q)
      klerp_pkg::S_IDLE: begin
        time_q <= item_i.day_ratio + klerp_pkg::HALF_DAY;
        scan_q <= '0;
      end
      klerp_pkg::S_SCAN: begin
        if (scan_q != LAST_KEY) scan_q <= scan_q + KW'(1);
        hi_q <= hi_sel;
        lo_q <= lo_sel;
      end
      klerp_pkg::S_RD_HI: t0_q <= kt_rdata_q;
      klerp_pkg::S_PREP: begin
        rem_q     <= d_val;
        span_q    <= span_val;
        step_q    <= '0;
        ch_q      <= '0;
        lo_base_q <= lo_lin[VW-1:0];
        hi_base_q <= hi_lin[VW-1:0];
        w_q       <= (span_val == 16'h0000) ? 16'h0000 : 16'hFFFF;
      end
      klerp_pkg::S_DIV: begin
        rem_q  <= ge ? 16'(rem2 - {1'b0, span_q}) : rem2[15:0];
        w_q    <= {w_q[14:0], ge};
        step_q <= step_q + 4'd1;
      end
      klerp_pkg::S_OUT: ch_q <= ch_q + 3'd1;
      default: ;
    endcase
    if (rd_vld_q) begin
      res_q.channel   <= rd_ch_q;
      res_q.value     <= acc[31:16];
      res_q.weight    <= w_q;
      res_q.lower_key <= lo_w[2:0];
      res_q.last      <= rd_last_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o)
    else $error("query results are not contiguous");

  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> res_o.channel == LAST_CH)
    else $error("last flag on the wrong channel");

  a_query_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.mode == klerp_pkg::MODE_QUERY |=> busy)
    else $error("query word did not start work");

  a_div_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == klerp_pkg::S_DIV |-> span_q != 16'h0000 && rem_q < span_q)
    else $error("divider running on bad operands");

endmodule
